/* rtl/mss_pkg.sv */
// shared types and constants of the maximum subarray extractor
package mss_pkg;

  localparam int DEPTH_DEF        = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int SUM_WIDTH        = 22;
  localparam int LEN_WIDTH        = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

  typedef struct packed {
    logic restart;
    logic better;
  } alu_flags_t;

endpackage

/* rtl/mss_store.sv */
// sample memory, one write port and one registered read port
module mss_store #(
  parameter int DEPTH        = mss_pkg::DEPTH_DEF,
  parameter int SAMPLE_WIDTH = mss_pkg::SAMPLE_WIDTH_DEF,
  localparam int AW          = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    wr_en_i,
  input  logic [AW-1:0]           wr_addr_i,
  input  logic [SAMPLE_WIDTH-1:0] wr_data_i,
  input  logic                    rd_en_i,
  input  logic [AW-1:0]           rd_addr_i,
  output logic [SAMPLE_WIDTH-1:0] rd_data_o
);

  logic [SAMPLE_WIDTH-1:0] mem_q [DEPTH];
  logic [SAMPLE_WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/mss_alu.sv */
// shared add, saturate and compare unit for the running sum
module mss_alu #(
  parameter int SAMPLE_WIDTH = mss_pkg::SAMPLE_WIDTH_DEF,
  localparam int RW = (mss_pkg::SUM_WIDTH > SAMPLE_WIDTH) ? mss_pkg::SUM_WIDTH : SAMPLE_WIDTH
) (
  input  logic signed [RW-1:0]           sum_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           first_i,
  input  logic signed [RW-1:0]           best_i,
  output logic signed [RW-1:0]           sum_o,
  output mss_pkg::alu_flags_t            flags_o
);

  localparam logic signed [RW:0] SUM_HI = (RW+1)'((2 ** (mss_pkg::SUM_WIDTH - 1)) - 1);
  localparam logic signed [RW:0] SUM_LO = (RW+1)'(-(2 ** (mss_pkg::SUM_WIDTH - 1)));

  logic signed [RW:0] ext_sum;
  logic signed [RW:0] ext_sample;
  logic signed [RW:0] ext_best;
  logic signed [RW:0] raw_sum;
  logic signed [RW:0] sat_sum;
  logic signed [RW:0] new_sum;

  always_comb begin
    ext_sum    = {sum_i[RW-1], sum_i};
    ext_sample = {{(RW + 1 - SAMPLE_WIDTH){sample_i[SAMPLE_WIDTH-1]}}, sample_i};
    ext_best   = {best_i[RW-1], best_i};
    raw_sum    = ext_sum + ext_sample;
    if (raw_sum > SUM_HI) begin
      sat_sum = SUM_HI;
    end else if (raw_sum < SUM_LO) begin
      sat_sum = SUM_LO;
    end else begin
      sat_sum = raw_sum;
    end
    // first sample or negative sum so far: start a new run at this sample
    flags_o.restart = first_i | sum_i[RW-1];
    new_sum         = flags_o.restart ? ext_sample : sat_sum;
    flags_o.better  = new_sum > ext_best;
    sum_o           = new_sum[RW-1:0];
  end

endmodule

/* rtl/max_subarray_sum_extract_core.sv */
// top level of the maximum subarray extractor: sequencer, state and stream ports
//
// Input stream (s_axis): one signed sample per request in tdata, tlast marks
// the final sample of a set. Each stored sample is first taken in and
// written to the sample memory, then the shared add, saturate and compare
// unit updates the running and best sums. tready is high only while the
// sequencer is idle. Samples past DEPTH are dropped and set the overflow
// flag, which travels on tuser of every result.
// Output stream (m_axis): after the tlast sample the best contiguous run is
// read back from the sample memory in order, one request per element, with
// best sum and run length in tdata and tlast on the final element. Each
// element is first read from the sample memory, then presented. When the
// receiver stalls, the current element simply holds until taken; no new
// samples are taken until the whole run is out, after which all state but
// the sample memory and the sample register is cleared for the next set.
// Reset clears the sequencer and all sums and counters; the sample memory
// is not cleared and needs no clearing pass.
module max_subarray_sum_extract_core #(
  parameter int DEPTH        = mss_pkg::DEPTH_DEF,
  parameter int SAMPLE_WIDTH = mss_pkg::SAMPLE_WIDTH_DEF,
  localparam int IN_TW  = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_BITS = mss_pkg::SUM_WIDTH + mss_pkg::LEN_WIDTH + SAMPLE_WIDTH,
  localparam int OUT_TW = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [IN_TW-1:0]  s_axis_tdata_i,   // sample
  input  logic              s_axis_tlast_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_TW-1:0] m_axis_tdata_o,   // best_sum, run_length, element
  output logic              m_axis_tlast_o,
  output logic              m_axis_tuser_o    // overflowed
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = (mss_pkg::SUM_WIDTH > SAMPLE_WIDTH) ? mss_pkg::SUM_WIDTH : SAMPLE_WIDTH;
  localparam int SW = mss_pkg::SUM_WIDTH;
  localparam int LW = mss_pkg::LEN_WIDTH;

  mss_pkg::state_e state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic signed [RW-1:0]    run_q, run_d;
  logic [AW-1:0]           run_start_q, run_start_d;
  logic signed [RW-1:0]    best_q, best_d;
  logic [AW-1:0]           best_start_q, best_start_d;
  logic [AW-1:0]           best_end_q, best_end_d;
  logic                    ovf_q, ovf_d;
  logic [SAMPLE_WIDTH-1:0] sample_q, sample_d;
  logic                    last_q, last_d;
  logic [AW-1:0]           ptr_q, ptr_d;

  logic                    wr_en;
  logic                    rd_en;
  logic [SAMPLE_WIDTH-1:0] rd_data;
  logic                    first;
  logic [AW-1:0]           idx;
  logic [AW-1:0]           new_start;
  logic                    better;
  logic signed [RW-1:0]    alu_sum;
  mss_pkg::alu_flags_t     alu_flags;
  logic [LW-1:0]           run_len;

  assign idx   = count_q[AW-1:0];
  assign first = (count_q == '0);

  mss_store #(
    .DEPTH        (DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx),
    .wr_data_i (s_axis_tdata_i[SAMPLE_WIDTH-1:0]),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q),
    .rd_data_o (rd_data)
  );

  mss_alu #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_alu (
    .sum_i    (run_q),
    .sample_i (sample_q),
    .first_i  (first),
    .best_i   (best_q),
    .sum_o    (alu_sum),
    .flags_o  (alu_flags)
  );

  assign new_start = alu_flags.restart ? idx : run_start_q;
  assign better    = first | alu_flags.better;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mss_pkg::ST_IDLE;
      count_q      <= '0;
      run_q        <= '0;
      run_start_q  <= '0;
      best_q       <= '0;
      best_start_q <= '0;
      best_end_q   <= '0;
      ovf_q        <= 1'b0;
      last_q       <= 1'b0;
      ptr_q        <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      run_q        <= run_d;
      run_start_q  <= run_start_d;
      best_q       <= best_d;
      best_start_q <= best_start_d;
      best_end_q   <= best_end_d;
      ovf_q        <= ovf_d;
      last_q       <= last_d;
      ptr_q        <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
  end

  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    run_d           = run_q;
    run_start_d     = run_start_q;
    best_d          = best_q;
    best_start_d    = best_start_q;
    best_end_d      = best_end_q;
    ovf_d           = ovf_q;
    sample_d        = sample_q;
    last_d          = last_q;
    ptr_d           = ptr_q;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    unique case (state_q)
      mss_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (count_q != CW'(DEPTH)) begin
            wr_en    = 1'b1;
            sample_d = s_axis_tdata_i[SAMPLE_WIDTH-1:0];
            last_d   = s_axis_tlast_i;
            state_d  = mss_pkg::ST_SCAN;
          end else begin
            // store full: drop the sample, the set may still close here
            ovf_d = 1'b1;
            if (s_axis_tlast_i) begin
              ptr_d   = best_start_q;
              state_d = mss_pkg::ST_EMIT_RD;
            end
          end
        end
      end
      mss_pkg::ST_SCAN: begin
        run_d       = alu_sum;
        run_start_d = new_start;
        if (better) begin
          best_d       = alu_sum;
          best_start_d = new_start;
          best_end_d   = idx;
        end
        count_d = count_q + 1'b1;
        if (last_q) begin
          ptr_d   = better ? new_start : best_start_q;
          state_d = mss_pkg::ST_EMIT_RD;
        end else begin
          state_d = mss_pkg::ST_IDLE;
        end
      end
      mss_pkg::ST_EMIT_RD: begin
        rd_en   = 1'b1;
        state_d = mss_pkg::ST_EMIT_OUT;
      end
      mss_pkg::ST_EMIT_OUT: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          if (ptr_q == best_end_q) begin
            count_d      = '0;
            run_d        = '0;
            run_start_d  = '0;
            best_d       = '0;
            best_start_d = '0;
            best_end_d   = '0;
            ovf_d        = 1'b0;
            last_d       = 1'b0;
            ptr_d        = '0;
            state_d      = mss_pkg::ST_IDLE;
          end else begin
            ptr_d   = ptr_q + 1'b1;
            state_d = mss_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = mss_pkg::ST_IDLE;
      end
    endcase
  end

  assign run_len = LW'(best_end_q) - LW'(best_start_q) + 1'b1;

  always_comb begin
    m_axis_tdata_o                                 = '0;
    m_axis_tdata_o[SW-1:0]                         = best_q[SW-1:0];
    m_axis_tdata_o[SW+LW-1:SW]                     = run_len;
    m_axis_tdata_o[SW+LW+SAMPLE_WIDTH-1:SW+LW]     = rd_data;
  end

  assign m_axis_tlast_o = (ptr_q == best_end_q);
  assign m_axis_tuser_o = ovf_q;

endmodule
